// ===== hw/rtl/mwr_pkg.sv =====
// mwr_pkg: shared types and constants for the microwire eeprom word reader
// item and result structs, pin phase numbering and the read command opcode
// no dependencies
`timescale 1ns / 1ps

package mwr_pkg;

	localparam int ADDRESS_BITS = 6;
	localparam int WORD_BITS    = 16;
	localparam int SETTLE_BITS  = 16;
	localparam int CMD_BITS     = ADDRESS_BITS + 3;
	localparam int PHASE_BITS   = 6;

	// phase numbering: deselect, select, command bits, data pulses, final deselect
	localparam logic [PHASE_BITS-1:0] PH_CMD0  = PHASE_BITS'(2);
	localparam logic [PHASE_BITS-1:0] PH_DATA0 = PHASE_BITS'(2 + 2 * CMD_BITS);
	localparam logic [PHASE_BITS-1:0] PH_LAST  = PHASE_BITS'(2 + 2 * CMD_BITS + 2 * WORD_BITS);

	// start bit and read opcode in front of the address
	localparam logic [2:0] READ_PREFIX = 3'b110;

	localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = SETTLE_BITS'(200);

	typedef struct packed {
		logic                    start_req;
		logic [ADDRESS_BITS-1:0] address;
		logic                    do_pin;
	} in_item_t;

	typedef struct packed {
		logic                 cs_pin;
		logic                 clk_pin;
		logic                 di_pin;
		logic                 busy_res;
		logic                 word_valid;
		logic [WORD_BITS-1:0] word;
	} out_item_t;

endpackage

// ===== hw/rtl/mwr_in_stage.sv =====
// mwr_in_stage: input register of the word reader
// holds one tick item until the sequencer takes it; depends on mwr_pkg
`timescale 1ns / 1ps

module mwr_in_stage import mwr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic take;

	// stall only while a held item cannot move on
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture on transfer
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

endmodule

// ===== hw/rtl/mwr_seq.sv =====
// mwr_seq: pin phase sequencer of the word reader
// keeps phase, hold count and shift registers; gives one result per tick
// depends on mwr_pkg
`timescale 1ns / 1ps

module mwr_seq import mwr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  in_item_t               item,
	input  logic [SETTLE_BITS-1:0] settle,
	output out_item_t              result
);

	logic [PHASE_BITS-1:0]  phase_q, phase_d, phase_e, rel;
	logic [SETTLE_BITS-1:0] hold_q, hold_d, hold_e, hold_inc, limit;
	logic [CMD_BITS-1:0]    cmd_q, cmd_d, cmd_e;
	logic [WORD_BITS-1:0]   data_q, data_d, data_e;
	logic                   active_q, active_d, active_e;
	logic                   start_take, done, valid;
	logic                   cs, sclk, di;
	logic [3:0]             bit_sel;

	// start is taken only while idle
	assign start_take = !active_q && item.start_req;
	assign active_e   = active_q || start_take;
	assign phase_e    = start_take ? '0 : phase_q;
	assign hold_e     = start_take ? '0 : hold_q;
	assign cmd_e      = start_take ? {READ_PREFIX, item.address} : cmd_q;
	assign data_e     = start_take ? '0 : data_q;

	// pin levels of the current phase
	assign rel     = phase_e - PH_CMD0;
	assign bit_sel = 4'(CMD_BITS - 1) - {1'b0, rel[3:1]} - {rel[4], 3'b000};
	always_comb begin
		cs   = 1'b0;
		sclk = 1'b0;
		di   = 1'b0;
		if (active_e && phase_e != '0 && phase_e < PH_LAST) begin
			cs = 1'b1;
			if (phase_e >= PH_CMD0) begin
				sclk = rel[0];
				if (phase_e < PH_DATA0) begin
					di = cmd_e[bit_sel];
				end
			end
		end
	end

	// hold counting and phase stepping
	assign limit    = (settle == '0) ? SETTLE_BITS'(1) : settle;
	assign hold_inc = hold_e + SETTLE_BITS'(1);
	assign done     = hold_inc >= limit;

	always_comb begin
		phase_d  = phase_e;
		hold_d   = hold_e;
		cmd_d    = cmd_e;
		data_d   = data_e;
		active_d = active_e;
		valid    = 1'b0;
		if (active_e) begin
			if (done) begin
				hold_d = '0;
				if (phase_e >= PH_DATA0 && phase_e < PH_LAST && rel[0]) begin
					data_d = {data_e[WORD_BITS-2:0], item.do_pin};
				end
				if (phase_e >= PH_LAST) begin
					active_d = 1'b0;
					phase_d  = '0;
					valid    = 1'b1;
				end else begin
					phase_d = phase_e + PHASE_BITS'(1);
				end
			end else begin
				hold_d = hold_inc;
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			hold_q   <= '0;
			cmd_q    <= '0;
			data_q   <= '0;
			active_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			hold_q   <= hold_d;
			cmd_q    <= cmd_d;
			data_q   <= data_d;
			active_q <= active_d;
		end
	end

	assign result.cs_pin     = cs;
	assign result.clk_pin    = sclk;
	assign result.di_pin     = di;
	assign result.busy_res   = active_d;
	assign result.word_valid = valid;
	assign result.word       = data_d;

endmodule

// ===== hw/rtl/microwire_eeprom_word_reader.sv =====
// microwire_eeprom_word_reader: top level of the microwire word read master
// settle register, input stage, sequencer and result register
// depends on mwr_pkg, mwr_in_stage, mwr_seq
`timescale 1ns / 1ps

// Each input transfer is one tick of the pin sequencer and gives exactly
// one result transfer with the pin levels, busy flag, word-valid pulse and
// the data shift register. A start request while idle latches the address
// and runs 53 pin phases, each held settle_ticks ticks (0 acts as 1).
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data;
// a transfer happens on a rising edge with valid high and stall low.
// cfg_valid/cfg_ready/cfg_data writes settle_ticks; cfg_ready is always
// high, and writes are expected only while no tick is in flight.
// A tick taken into the input register shows on out_data after it moves
// into the result register. Throughput: one tick per cycle while out_stall
// is low, set by the single input and result registers around the sequencer.
// A stall on the output holds the result; the input stalls only when the
// input register is full and cannot move into the result register.
// Reset clears the sequencer to idle, empties both registers and loads
// settle_ticks with 200.
module microwire_eeprom_word_reader import mwr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SETTLE_BITS-1:0] cfg_data
);

	logic                   valid_s1, advance, out_valid_s2;
	in_item_t               item_s1;
	out_item_t              result, result_s2;
	logic [SETTLE_BITS-1:0] settle_q;

	// settle register write
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= cfg_data;
		end
	end

	// move when the result register is empty or being drained
	assign advance = valid_s1 && (!out_valid_s2 || !out_stall);

	mwr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mwr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.settle  (settle_q),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = result_s2;

endmodule
